FILE: design/artnet_packet_dispatcher_assert.svh
// Assertion helpers shared by the dispatcher modules.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ARTNET_PACKET_DISPATCHER_ASSERT_SVH
`define ARTNET_PACKET_DISPATCHER_ASSERT_SVH

// Same-cycle implication.
`define APD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define APD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/apd_pkg.sv
package apd_pkg;

  typedef struct packed {
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] source_ip;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [2:0]  action;
    logic [15:0] universe;
    logic [15:0] frame_length;
    logic [7:0]  priority_res;
    logic [7:0]  start_code;
    logic [31:0] sender_ip;
    logic [7:0]  payload_byte;
    logic [9:0]  payload_index;
    logic        last;
  } out_t;

  // Queue write strobes: first entry, and a second one behind it.
  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  localparam logic [15:0] OP_DMX  = 16'h0050;
  localparam logic [15:0] OP_SYNC = 16'h0053;
  localparam logic [15:0] OP_POLL = 16'h0200;
  localparam logic [15:0] OP_NZS  = 16'h0058;

  localparam logic [15:0] POS_OPC_LO  = 16'd8;
  localparam logic [15:0] POS_OPC_HI  = 16'd9;
  localparam logic [15:0] POS_UNI_LO  = 16'd14;
  localparam logic [15:0] POS_UNI_HI  = 16'd15;
  localparam logic [15:0] POS_LEN_HI  = 16'd16;
  localparam logic [15:0] POS_LEN_LO  = 16'd17;
  localparam logic [15:0] PRIO_AT     = 16'd59;
  localparam logic [15:0] DMX_DATA_AT = 16'd60;
  localparam logic [15:0] NZS_DATA_AT = 16'd61;
  localparam logic [15:0] DMX_MIN_LEN = 16'd18;
  localparam logic [15:0] HDR_MIN_LEN = 16'd10;

  localparam logic [2:0] ACT_REJECT = 3'd0;
  localparam logic [2:0] ACT_DMX    = 3'd1;
  localparam logic [2:0] ACT_SYNC   = 3'd2;
  localparam logic [2:0] ACT_NZS    = 3'd3;
  localparam logic [2:0] ACT_POLL   = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam logic [7:0] DEFAULT_PRIO_RST = 8'd100;

  localparam int CFG_ADDR_W = 3;
  localparam logic REG_DEFAULT_PRIO = 1'b0;

  localparam int RQ_DEPTH = 4;

endpackage

FILE: design/apd_parse.sv
`include "artnet_packet_dispatcher_assert.svh"

module apd_parse #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  apd_pkg::in_t  in_item,
  input  logic [7:0]    default_priority,
  output apd_pkg::push_t push,
  output apd_pkg::out_t res0,
  output apd_pkg::out_t res1
);

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      opc_r, opc_nxt;
  logic [15:0]      uni_r, uni_nxt;
  logic [15:0]      len_r, len_nxt;
  logic [7:0]       prio_r, prio_nxt;
  logic [7:0]       sc_r, sc_nxt;
  logic [31:0]      ip_r, ip_nxt;

  logic [15:0]      pos16;
  logic             active;
  logic [7:0]       byte_in;
  logic [15:0]      opc_cur, uni_cur, len_cur;
  logic [7:0]       prio_cur, sc_cur;
  logic [31:0]      ip_cur;
  logic [POS_W-1:0] pos_inc;
  logic [15:0]      dmx_idx, nzs_idx;
  logic             dmx_pay, nzs_pay, pay_vld;
  logic [15:0]      len16, dmx_avail, nzs_avail;
  apd_pkg::out_t    pay_res, ver_res;

  assign pos16   = 16'(pos_r);
  assign active  = pos_r < POS_MAX;
  assign byte_in = in_item.packet_byte;

  // Capture header fields with the current byte so this byte's checks see them.
  always_comb begin
    opc_cur  = opc_r;
    uni_cur  = uni_r;
    len_cur  = len_r;
    prio_cur = prio_r;
    sc_cur   = sc_r;
    if (active) begin
      case (pos16)
        apd_pkg::POS_OPC_LO:  opc_cur[7:0]  = byte_in;
        apd_pkg::POS_OPC_HI:  opc_cur[15:8] = byte_in;
        apd_pkg::POS_UNI_LO:  uni_cur[7:0]  = byte_in;
        apd_pkg::POS_UNI_HI:  uni_cur[15:8] = byte_in;
        apd_pkg::POS_LEN_HI:  len_cur[15:8] = byte_in;
        apd_pkg::POS_LEN_LO:  len_cur[7:0]  = byte_in;
        apd_pkg::PRIO_AT:     prio_cur      = byte_in;
        apd_pkg::DMX_DATA_AT: sc_cur        = byte_in;
        default: ;
      endcase
    end
  end

  assign ip_cur  = (pos_r == '0) ? in_item.source_ip : ip_r;
  assign pos_inc = active ? pos_r + 1'b1 : pos_r;

  assign dmx_idx = pos16 - apd_pkg::DMX_DATA_AT;
  assign nzs_idx = pos16 - apd_pkg::NZS_DATA_AT;
  assign dmx_pay = active && (opc_cur == apd_pkg::OP_DMX) &&
                   (pos16 >= apd_pkg::DMX_DATA_AT) && (dmx_idx < len_cur);
  assign nzs_pay = active && (opc_cur == apd_pkg::OP_NZS) &&
                   (pos16 >= apd_pkg::NZS_DATA_AT) && (nzs_idx < len_cur);
  assign pay_vld = dmx_pay || nzs_pay;

  always_comb begin
    pay_res               = '0;
    pay_res.result_kind   = apd_pkg::KIND_PAYLOAD;
    pay_res.action        = dmx_pay ? apd_pkg::ACT_DMX : apd_pkg::ACT_NZS;
    pay_res.universe      = uni_cur;
    pay_res.frame_length  = len_cur;
    pay_res.priority_res  = prio_cur;
    pay_res.start_code    = dmx_pay ? 8'd0 : sc_cur;
    pay_res.sender_ip     = ip_cur;
    pay_res.payload_byte  = byte_in;
    pay_res.payload_index = dmx_pay ? dmx_idx[9:0] : nzs_idx[9:0];
    pay_res.last          = 1'b0;
  end

  assign len16     = 16'(pos_inc);
  assign dmx_avail = (len16 >= apd_pkg::DMX_DATA_AT) ? len16 - apd_pkg::DMX_DATA_AT : 16'd0;
  assign nzs_avail = len16 - apd_pkg::NZS_DATA_AT;

  always_comb begin
    ver_res             = '0;
    ver_res.result_kind = apd_pkg::KIND_VERDICT;
    ver_res.action      = apd_pkg::ACT_REJECT;
    ver_res.sender_ip   = ip_cur;
    ver_res.last        = 1'b1;
    if (len16 >= apd_pkg::HDR_MIN_LEN) begin
      if (opc_cur == apd_pkg::OP_DMX) begin
        if (len16 >= apd_pkg::DMX_MIN_LEN) begin
          ver_res.action       = apd_pkg::ACT_DMX;
          ver_res.universe     = uni_cur;
          ver_res.frame_length = (len_cur < dmx_avail) ? len_cur : dmx_avail;
          ver_res.priority_res = (len16 > apd_pkg::PRIO_AT) ? prio_cur : default_priority;
        end
      end else if (opc_cur == apd_pkg::OP_SYNC) begin
        ver_res.action = apd_pkg::ACT_SYNC;
      end else if (opc_cur == apd_pkg::OP_POLL) begin
        ver_res.action = apd_pkg::ACT_POLL;
      end else if (opc_cur == apd_pkg::OP_NZS) begin
        if (len16 >= apd_pkg::NZS_DATA_AT) begin
          ver_res.action       = apd_pkg::ACT_NZS;
          ver_res.universe     = uni_cur;
          ver_res.frame_length = (len_cur < nzs_avail) ? len_cur : nzs_avail;
          ver_res.priority_res = prio_cur;
          ver_res.start_code   = sc_cur;
        end
      end
    end
  end

  // Payload result goes ahead of the verdict when one byte makes both.
  assign push.first  = in_fire && (pay_vld || in_item.last_byte);
  assign push.second = in_fire && pay_vld && in_item.last_byte;
  assign res0        = pay_vld ? pay_res : ver_res;
  assign res1        = ver_res;

  always_comb begin
    pos_nxt  = pos_r;
    opc_nxt  = opc_r;
    uni_nxt  = uni_r;
    len_nxt  = len_r;
    prio_nxt = prio_r;
    sc_nxt   = sc_r;
    ip_nxt   = ip_r;
    if (in_fire) begin
      if (in_item.last_byte) begin
        // Drop all packet context after the closing byte.
        pos_nxt  = '0;
        opc_nxt  = '0;
        uni_nxt  = '0;
        len_nxt  = '0;
        prio_nxt = '0;
        sc_nxt   = '0;
        ip_nxt   = '0;
      end else begin
        pos_nxt  = pos_inc;
        opc_nxt  = opc_cur;
        uni_nxt  = uni_cur;
        len_nxt  = len_cur;
        prio_nxt = prio_cur;
        sc_nxt   = sc_cur;
        ip_nxt   = ip_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      opc_r  <= '0;
      uni_r  <= '0;
      len_r  <= '0;
      prio_r <= '0;
      sc_r   <= '0;
      ip_r   <= '0;
    end else begin
      pos_r  <= pos_nxt;
      opc_r  <= opc_nxt;
      uni_r  <= uni_nxt;
      len_r  <= len_nxt;
      prio_r <= prio_nxt;
      sc_r   <= sc_nxt;
      ip_r   <= ip_nxt;
    end
  end

  `APD_ASSERT_NXT(a_pos_clear_after_last, in_fire && in_item.last_byte, pos_r == '0, "byte position not cleared after last byte")
  `APD_ASSERT_IMP(a_payload_in_data_area, pay_vld, (pos16 >= apd_pkg::DMX_DATA_AT) && active, "payload byte outside data area")

endmodule

FILE: design/apd_resq.sv
`include "artnet_packet_dispatcher_assert.svh"

module apd_resq (
  input  logic           clk,
  input  logic           rst_n,
  input  apd_pkg::push_t push,
  input  apd_pkg::out_t  d0,
  input  apd_pkg::out_t  d1,
  output logic           space_ok,
  output logic           out_valid,
  input  logic           out_ready,
  output apd_pkg::out_t  out_data
);

  localparam int PTR_W = $clog2(apd_pkg::RQ_DEPTH);
  localparam int CNT_W = $clog2(apd_pkg::RQ_DEPTH + 1);

  apd_pkg::out_t    mem [apd_pkg::RQ_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid = cnt_r != '0;
  assign out_data  = mem[rd_r];
  assign pop       = out_valid && out_ready;
  // Room for two more results regardless of this cycle's pop.
  assign space_ok  = cnt_r <= CNT_W'(apd_pkg::RQ_DEPTH - 2);

  assign wr_nxt  = wr_r + PTR_W'(push.first) + PTR_W'(push.second);
  assign rd_nxt  = rd_r + PTR_W'(pop);
  assign cnt_nxt = cnt_r + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_r] <= d0;
    end
    if (push.second) begin
      mem[wr_r + 1'b1] <= d1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `APD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(apd_pkg::RQ_DEPTH), "result queue overflow")
  `APD_ASSERT_IMP(a_push_order, push.second, push.first, "second push without first")
  `APD_ASSERT_NXT(a_two_push_count, push.second && !pop, cnt_r == $past(cnt_r) + CNT_W'(2), "count missed a double push")

endmodule

FILE: design/artnet_packet_dispatcher.sv
// Art-Net style packet dispatcher. Takes one packet byte per transfer on the in_ channel (byte
// zero first, last_byte on the final one) and accepts a byte every clock while its four-entry
// result queue has room for two results. Each byte is parsed combinationally; a DMX or NZS
// payload byte inside the declared length yields a payload result at once, and the final byte
// yields a verdict result (after the payload result when it is both). Results leave in order,
// one per clock on the out_ channel while out_ready is high; a byte enters that queue on the cycle
// it is accepted, so a result is visible the cycle after its byte. Input stalls only when the out_
// side holds off and over two results are queued. Bytes past MAX_PACKET_BYTES are dropped but still
// close the packet. The single register, default_priority, sits at byte address 0 of the cfg_ port.
module artnet_packet_dispatcher #(
  parameter int MAX_PACKET_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  apd_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output apd_pkg::out_t                 out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [apd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  logic           in_fire;
  logic           space_ok;
  logic           cfg_wr;
  logic [7:0]     dflt_prio_r, dflt_prio_nxt;
  apd_pkg::push_t push;
  apd_pkg::out_t  res0, res1;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == apd_pkg::REG_DEFAULT_PRIO) ? {24'd0, dflt_prio_r} : 32'd0;

  assign dflt_prio_nxt = (cfg_wr && cfg_paddr[2] == apd_pkg::REG_DEFAULT_PRIO) ?
                         cfg_pwdata[7:0] : dflt_prio_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_prio_r <= apd_pkg::DEFAULT_PRIO_RST;
    end else begin
      dflt_prio_r <= dflt_prio_nxt;
    end
  end

  assign in_ready = space_ok;
  assign in_fire  = in_valid && in_ready;

  apd_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_parse (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_fire          (in_fire),
    .in_item          (in_data),
    .default_priority (dflt_prio_r),
    .push             (push),
    .res0             (res0),
    .res1             (res1)
  );

  apd_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .d0        (res0),
    .d1        (res1),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
